// ===== rtl/packet_bitmap_engine_assert.svh =====
// Assertion macros for the packet bitmap engine.
// Both use clk_i and rst_ni of the module that includes this file.
`ifndef PACKET_BITMAP_ENGINE_ASSERT_SVH
`define PACKET_BITMAP_ENGINE_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define PBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define PBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pbe_pkg.sv =====
`default_nettype none

package pbe_pkg;

  localparam int unsigned DEF_LAST_BYTE = 63;
  localparam int unsigned WIN_MAX       = 16;

  localparam logic [2:0] OP_COUNT = 3'd0;
  localparam logic [2:0] OP_TEST  = 3'd1;
  localparam logic [2:0] OP_CLR   = 3'd2;
  localparam logic [2:0] OP_SET   = 3'd3;
  localparam logic [2:0] OP_FILL  = 3'd4;
  localparam logic [2:0] OP_WIN   = 3'd5;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_SET   = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, b[i]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/packet_bitmap_engine.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   40     opcode[2:0], bit_index[18:3], bit_count[34:19]
// m_axis    out  24     status[1:0], value[17:2]
//
// After reset a clearing pass writes zero to all LAST_BYTE+1 bytes, one byte a cycle,
// with s_axis_tready low. Count ones makes one RAM read per byte into a shared popcount
// adder; prefix fill writes 0xFF below byte_index, then the partial byte; test, clear
// and set read one byte, a window read three, and an index overflow, a rejected window
// or an unused opcode goes straight to S_OUT. A finished word waits in the output register
// while the next request is taken; a result that finds it full holds until m_axis_tready.
`default_nettype none

module packet_bitmap_engine #(
  parameter int unsigned LAST_BYTE = pbe_pkg::DEF_LAST_BYTE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // opcode, bit_index, bit_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status, value
);

  import pbe_pkg::*;

`include "packet_bitmap_engine_assert.svh"

  localparam int unsigned MAP_BYTES = LAST_BYTE + 1;
  localparam int unsigned AW        = $clog2(MAP_BYTES);
  localparam int unsigned KW        = $clog2(MAP_BYTES + 1);
  localparam int unsigned SW        = KW + 1;

  localparam logic [AW-1:0] LAST_ADDR = AW'(LAST_BYTE);
  localparam logic [KW-1:0] MAP_CNT   = KW'(MAP_BYTES);
  localparam logic [KW-1:0] WIN_READS = KW'(3);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [2:0]    op_q, op_d;
  logic [15:0]   idx_q, idx_d;
  logic [15:0]   cnt_q, cnt_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] lim_q, lim_d;
  logic [KW-1:0] n_q, n_d;
  logic [KW-1:0] k_q, k_d;
  logic          pend_q, pend_d;
  logic [15:0]   acc_q, acc_d;
  logic [23:0]   win_q, win_d;
  logic [1:0]    r_status_q, r_status_d;
  logic [15:0]   r_value_q, r_value_d;
  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [15:0]   out_value_q;
  logic          ld_out;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic [2:0]    in_op;
  logic [15:0]   in_idx;
  logic [15:0]   in_cnt;
  logic [12:0]   in_byte;
  logic          in_ovf;
  logic [16:0]   in_last;
  logic [13:0]   in_lastb;
  logic          win_bad;
  logic [16:0]   nb_sum;
  logic [13:0]   nb_raw;
  logic [KW-1:0] nb_sat;

  logic [SW-1:0] rd_sum;
  logic [7:0]    bit_mask;
  logic [7:0]    fill_mask;
  logic [23:0]   win_shift;
  logic [15:0]   win_mask;

  assign in_op    = s_axis_tdata[2:0];
  assign in_idx   = s_axis_tdata[18:3];
  assign in_cnt   = s_axis_tdata[34:19];
  assign in_byte  = in_idx[15:3];
  assign in_ovf   = in_byte > 13'(LAST_BYTE);
  assign in_last  = {1'b0, in_idx} + {1'b0, in_cnt} - 17'd1;
  assign in_lastb = in_last[16:3];
  assign win_bad  = (in_cnt == 16'd0) || (in_cnt > 16'(WIN_MAX)) || in_ovf ||
                    (in_lastb > 14'(LAST_BYTE));
  assign nb_sum   = {1'b0, in_cnt} + 17'd7;
  assign nb_raw   = nb_sum[16:3];
  assign nb_sat   = (nb_raw > 14'(MAP_BYTES)) ? MAP_CNT : KW'(nb_raw);

  assign rd_sum    = SW'(base_q) + SW'(k_q);
  assign mem_raddr = (rd_sum > SW'(lim_q)) ? lim_q : rd_sum[AW-1:0];
  assign bit_mask  = 8'd1 << idx_q[2:0];
  assign fill_mask = bit_mask - 8'd1;
  assign win_shift = win_q >> idx_q[2:0];
  assign win_mask  = cnt_q[4] ? 16'hFFFF : 16'((17'd1 << cnt_q[3:0]) - 17'd1);

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    base_d     = base_q;
    lim_d      = lim_q;
    n_d        = n_q;
    k_d        = k_q;
    pend_d     = pend_q;
    acc_d      = acc_q;
    win_d      = win_q;
    r_status_d = r_status_q;
    r_value_d  = r_value_q;
    mem_we     = 1'b0;
    mem_waddr  = k_q[AW-1:0];
    mem_wdata  = 8'h00;
    mem_re     = 1'b0;
    ld_out     = 1'b0;
    case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        if (k_q == KW'(LAST_BYTE)) begin
          k_d     = '0;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d       = in_op;
          idx_d      = in_idx;
          cnt_d      = in_cnt;
          k_d        = '0;
          pend_d     = 1'b0;
          acc_d      = '0;
          r_status_d = ST_CLEAR;
          r_value_d  = '0;
          case (in_op)
            OP_COUNT: begin
              base_d  = '0;
              lim_d   = LAST_ADDR;
              n_d     = nb_sat;
              state_d = S_RD;
            end
            OP_TEST, OP_CLR, OP_SET: begin
              if (in_ovf) begin
                r_status_d = ST_OVF;
                state_d    = S_OUT;
              end else begin
                base_d  = AW'(in_byte);
                lim_d   = AW'(in_byte);
                n_d     = KW'(1);
                state_d = S_RD;
              end
            end
            OP_FILL: begin
              if (in_ovf) begin
                r_status_d = ST_OVF;
                state_d    = S_OUT;
              end else begin
                base_d  = AW'(in_byte);
                state_d = S_FILL;
              end
            end
            OP_WIN: begin
              if (win_bad) begin
                state_d = S_OUT;
              end else begin
                base_d  = AW'(in_byte);
                lim_d   = AW'(in_lastb);
                n_d     = WIN_READS;
                state_d = S_RD;
              end
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_RD: begin
        mem_re = (k_q < n_q);
        pend_d = mem_re;
        if (mem_re) begin
          k_d = k_q + KW'(1);
        end
        if (pend_q) begin
          if (op_q == OP_COUNT) begin
            acc_d = acc_q + 16'(pop8(mem_rdata));
          end else begin
            win_d = {mem_rdata, win_q[23:8]};
          end
        end
        if (!mem_re && !pend_q) begin
          state_d = S_OUT;
          case (op_q)
            OP_COUNT: r_value_d = acc_q;
            OP_TEST:  r_status_d = mem_rdata[idx_q[2:0]] ? ST_SET : ST_CLEAR;
            OP_CLR: begin
              mem_we     = 1'b1;
              mem_waddr  = base_q;
              mem_wdata  = mem_rdata & ~bit_mask;
              r_status_d = ST_CLEAR;
            end
            OP_SET: begin
              mem_we     = 1'b1;
              mem_waddr  = base_q;
              mem_wdata  = mem_rdata | bit_mask;
              r_status_d = ST_SET;
            end
            OP_WIN:   r_value_d = win_shift[15:0] & win_mask;
            default:  r_value_d = '0;
          endcase
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        if (k_q == KW'(base_q)) begin
          mem_wdata = fill_mask;
          r_value_d = idx_q;
          state_d   = S_OUT;
        end else begin
          mem_wdata = 8'hFF;
          k_d       = k_q + KW'(1);
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          ld_out  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    base_q     <= base_d;
    lim_q      <= lim_d;
    n_q        <= n_d;
    acc_q      <= acc_d;
    win_q      <= win_d;
    r_status_q <= r_status_d;
    r_value_q  <= r_value_d;
    if (ld_out) begin
      out_status_q <= r_status_q;
      out_value_q  <= r_value_q;
    end
  end

  pbe_ram #(
    .DEPTH (MAP_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_value_q, out_status_q};

  `PBE_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, state_q != S_IDLE,
    "accepted word did not start work")
  `PBE_ASSERT(a_we_busy, mem_we |-> (state_q != S_IDLE && state_q != S_OUT),
    "bitmap write outside a working state")
  `PBE_ASSERT(a_k_range, k_q <= MAP_CNT, "byte counter past map size")
  `PBE_ASSERT(a_pend_rd, pend_q |-> (state_q == S_RD), "read pending outside read loop")
  `PBE_ASSERT_NEXT(a_load_out, state_q == S_OUT && (!out_valid_q || m_axis_tready),
    m_axis_tvalid, "finished result not presented")

endmodule

`default_nettype wire

// ===== rtl/pbe_ram.sv =====
`default_nettype none

module pbe_ram #(
  parameter int unsigned DEPTH = pbe_pkg::DEF_LAST_BYTE + 1,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  import pbe_pkg::*;

  localparam logic [2:0]  OP_RSVD6   = 3'd6;
  localparam logic [2:0]  OP_RSVD7   = 3'd7;
  localparam int unsigned MAP_BYTES  = DEF_LAST_BYTE + 1;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT = 100;
  localparam int unsigned N_RANDOM   = 1450;
  localparam int unsigned MAX_PRINTS = 40;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] bit_index;
    logic [15:0] bit_count;
    logic        wait_idle;
  } bitmap_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value;
  } bitmap_rsp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // opcode, bit_index, bit_count, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // status, value, zero pad

  bitmap_req_t request_queue[$];
  bitmap_rsp_t pending_results[$];
  logic [7:0]  bitmap_shadow [MAP_BYTES];

  logic        req_taken     = 1'b0;
  int unsigned tx_gap        = 0;
  bit          tx_calm       = 1'b0;
  int unsigned rx_gap        = 0;
  bit          rx_calm       = 1'b0;
  int unsigned rx_cycle      = 0;
  int unsigned total_reqs    = 0;
  int unsigned accepted_reqs = 0;
  int unsigned checked_words = 0;
  int unsigned ovf_words     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned mismatches    = 0;
  int unsigned op_seen [8];

  packet_bitmap_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  task automatic log_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic apply_request(input bitmap_req_t rq, output bitmap_rsp_t rs);
    int unsigned byte_i;
    int unsigned bit_i;
    int unsigned nbytes;
    int unsigned ones;
    int unsigned last_bit;
    int unsigned p;
    byte_i    = 32'(rq.bit_index) >> 3;
    bit_i     = 32'(rq.bit_index) & 32'd7;
    rs.status = ST_CLEAR;
    rs.value  = '0;
    case (rq.opcode)
      OP_COUNT: begin
        nbytes = (32'(rq.bit_count) + 32'd7) >> 3;
        if (nbytes > MAP_BYTES) nbytes = MAP_BYTES;
        ones = 0;
        for (int unsigned k = 0; k < nbytes; k++) begin
          for (int b = 0; b < 8; b++) ones += bitmap_shadow[k][b];
        end
        rs.value = ones[15:0];
      end
      OP_TEST: begin
        if (byte_i > DEF_LAST_BYTE) rs.status = ST_OVF;
        else rs.status = bitmap_shadow[byte_i][bit_i] ? ST_SET : ST_CLEAR;
      end
      OP_CLR: begin
        if (byte_i > DEF_LAST_BYTE) rs.status = ST_OVF;
        else bitmap_shadow[byte_i][bit_i] = 1'b0;
      end
      OP_SET: begin
        if (byte_i > DEF_LAST_BYTE) rs.status = ST_OVF;
        else begin
          bitmap_shadow[byte_i][bit_i] = 1'b1;
          rs.status = ST_SET;
        end
      end
      OP_FILL: begin
        if (byte_i > DEF_LAST_BYTE) rs.status = ST_OVF;
        else begin
          for (int unsigned k = 0; k < byte_i; k++) bitmap_shadow[k] = 8'hFF;
          bitmap_shadow[byte_i] = (8'h01 << bit_i) - 8'h01;
          rs.value = rq.bit_index;
        end
      end
      OP_WIN: begin
        last_bit = 32'(rq.bit_index) + 32'(rq.bit_count) - 32'd1;
        if (rq.bit_count != 0 && rq.bit_count <= WIN_MAX && byte_i <= DEF_LAST_BYTE &&
            (last_bit >> 3) <= DEF_LAST_BYTE) begin
          for (int unsigned k = 0; k < rq.bit_count; k++) begin
            p = 32'(rq.bit_index) + k;
            rs.value[k] = bitmap_shadow[p >> 3][p & 32'd7];
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic add_req(input logic [2:0] op, input logic [15:0] idx,
                         input logic [15:0] cnt, input logic hold);
    bitmap_req_t rq;
    rq.opcode    = op;
    rq.bit_index = idx;
    rq.bit_count = cnt;
    rq.wait_idle = hold;
    request_queue.push_back(rq);
  endtask

  function automatic bitmap_req_t random_request();
    bitmap_req_t rq;
    int unsigned pick;
    pick         = $urandom_range(99);
    rq.bit_index = ($urandom_range(99) < 88) ? 16'($urandom_range(511)) : 16'($urandom);
    rq.bit_count = 16'($urandom);
    rq.wait_idle = ($urandom_range(299) == 0);
    if (pick < 12) begin
      rq.opcode = OP_COUNT;
      if ($urandom_range(9) < 8) rq.bit_count = 16'($urandom_range(520));
    end else if (pick < 32) begin
      rq.opcode = OP_TEST;
    end else if (pick < 53) begin
      rq.opcode = OP_CLR;
    end else if (pick < 75) begin
      rq.opcode = OP_SET;
    end else if (pick < 83) begin
      rq.opcode = OP_FILL;
    end else if (pick < 97) begin
      rq.opcode = OP_WIN;
      if ($urandom_range(99) < 85) rq.bit_count = 16'($urandom_range(16, 1));
      else if ($urandom_range(1) == 0) rq.bit_count = '0;
    end else begin
      rq.opcode = pick[0] ? OP_RSVD7 : OP_RSVD6;
    end
    return rq;
  endfunction

  // Sender: advance to the next word once the current one is taken.
  always @(negedge clk_i) begin : drv
    bitmap_req_t rq;
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (request_queue.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (request_queue[0].wait_idle && pending_results.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        rq = request_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, rq.bit_count, rq.bit_index, rq.opcode};
        if ($urandom_range(149) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : draw_gap();
      end
    end
  end

  // Receiver: stall at random, with calm stretches.
  always @(negedge clk_i) begin : rcv
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_calm = ($urandom_range(3) == 0);
    if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_calm && $urandom_range(99) < 40) rx_gap = draw_gap();
    end
  end

  always @(posedge clk_i) begin : mon
    bitmap_req_t rq;
    bitmap_rsp_t got;
    bitmap_rsp_t want;
    if (rst_ni) begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[1:0];
        got.value  = m_axis_tdata[17:2];
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("word with nothing pending: status %0d value %0d",
                                 got.status, got.value));
        end else begin
          want = pending_results.pop_front();
          checked_words++;
          if (got.status !== want.status)
            log_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.value !== want.value)
            log_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rq.opcode    = s_axis_tdata[2:0];
        rq.bit_index = s_axis_tdata[18:3];
        rq.bit_count = s_axis_tdata[34:19];
        rq.wait_idle = 1'b0;
        apply_request(rq, want);
        pending_results.push_back(want);
        if (want.status == ST_OVF) ovf_words++;
        op_seen[rq.opcode]++;
        accepted_reqs++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k < MAP_BYTES; k++) bitmap_shadow[k] = 8'h00;

    add_req(OP_COUNT, 16'd0,     16'd0,     1'b0);
    add_req(OP_COUNT, 16'hFFFF,  16'hFFFF,  1'b0);
    add_req(OP_SET,   16'd0,     16'd0,     1'b0);
    add_req(OP_SET,   16'd511,   16'hFFFF,  1'b0);
    add_req(OP_TEST,  16'd511,   16'd0,     1'b0);
    add_req(OP_TEST,  16'd510,   16'd0,     1'b0);
    add_req(OP_CLR,   16'd511,   16'd0,     1'b0);
    add_req(OP_TEST,  16'd512,   16'd0,     1'b0);
    add_req(OP_SET,   16'hFFFF,  16'd0,     1'b0);
    add_req(OP_CLR,   16'hFFFF,  16'hFFFF,  1'b0);
    add_req(OP_FILL,  16'd13,    16'd0,     1'b0);
    add_req(OP_FILL,  16'd0,     16'd0,     1'b0);
    add_req(OP_FILL,  16'd512,   16'd0,     1'b0);
    add_req(OP_FILL,  16'd511,   16'd0,     1'b0);
    add_req(OP_COUNT, 16'd0,     16'd1,     1'b0);
    add_req(OP_COUNT, 16'd0,     16'd513,   1'b0);
    add_req(OP_WIN,   16'd8,     16'd0,     1'b0);
    add_req(OP_WIN,   16'd8,     16'd17,    1'b0);
    add_req(OP_WIN,   16'd500,   16'd16,    1'b0);
    add_req(OP_WIN,   16'd496,   16'd16,    1'b0);
    add_req(OP_WIN,   16'd5,     16'd1,     1'b0);
    add_req(OP_WIN,   16'hFFFF,  16'd16,    1'b0);
    add_req(OP_RSVD6, 16'hFFFF,  16'hFFFF,  1'b0);
    add_req(OP_RSVD7, 16'd0,     16'd0,     1'b0);
    add_req(OP_COUNT, 16'd0,     16'hFFFF,  1'b0);

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      request_queue.push_back(random_request());
      if (n == 0) request_queue[request_queue.size() - 1].wait_idle = 1'b1;
    end
    total_reqs = request_queue.size();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_reqs == total_reqs && pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d requests: %0d count, %0d test, %0d clear, %0d set, %0d fill, %0d window,",
             accepted_reqs, op_seen[OP_COUNT], op_seen[OP_TEST], op_seen[OP_CLR],
             op_seen[OP_SET], op_seen[OP_FILL], op_seen[OP_WIN]);
    $display("  %0d unused opcode; %0d words checked, %0d overflow, %0d mismatches",
             op_seen[OP_RSVD6] + op_seen[OP_RSVD7], checked_words, ovf_words, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
